FILE: src/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master byte transfer: shared package
// Phase codes, register indexes, reset values and the item types used by the
// channels and between the sequencer, the register bank and the top level.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam int HalfDelayW = 8;
	localparam int StopGapW   = 16;
	localparam int CfgIdxW    = 2;

	typedef logic [4:0] phase_t;

	localparam phase_t PH_IDLE = 5'd0;
	localparam phase_t PH_ST0  = 5'd1;
	localparam phase_t PH_ST1  = 5'd2;
	localparam phase_t PH_ST2  = 5'd3;
	localparam phase_t PH_ST3  = 5'd4;
	localparam phase_t PH_WSET = 5'd5;
	localparam phase_t PH_WHI  = 5'd6;
	localparam phase_t PH_WLO  = 5'd7;
	localparam phase_t PH_AHI  = 5'd8;
	localparam phase_t PH_ALO  = 5'd9;
	localparam phase_t PH_RPRE = 5'd10;
	localparam phase_t PH_RHI  = 5'd11;
	localparam phase_t PH_RLO  = 5'd12;
	localparam phase_t PH_N0   = 5'd13;
	localparam phase_t PH_N1   = 5'd14;
	localparam phase_t PH_N2   = 5'd15;
	localparam phase_t PH_N3   = 5'd16;
	localparam phase_t PH_P0   = 5'd17;
	localparam phase_t PH_P1   = 5'd18;
	localparam phase_t PH_P2   = 5'd19;
	localparam phase_t PH_GAP  = 5'd20;
	localparam phase_t PH_DONE = 5'd21;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	localparam logic [CfgIdxW-1:0] CFG_HALF_DELAY = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_STOP_GAP   = 2'd1;

	localparam logic [HalfDelayW-1:0] HALF_DELAY_RST = 8'd5;
	localparam logic [StopGapW-1:0]   STOP_GAP_RST   = 16'd1000;

	typedef struct packed {
		logic       start_req;
		logic       mode;
		logic [7:0] addr_byte;
		logic [7:0] write_byte;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic       success;
		logic [7:0] read_byte;
	} result_t;

	typedef struct packed {
		logic [CfgIdxW-1:0]  index;
		logic [StopGapW-1:0] wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic [HalfDelayW-1:0] half_delay;
		logic [StopGapW-1:0]   stop_gap;
	} cfg_t;

endpackage

FILE: src/i2cm_chan_if.sv
// ----------------------------------------------------------------------------
// I2C master byte transfer: handshake channel
// A valid/ready channel carrying one item of the payload type T.
// ----------------------------------------------------------------------------
interface i2cm_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/i2cm_cfg_regs.sv
// ----------------------------------------------------------------------------
// I2C master byte transfer: configuration registers
// Holds the step hold time and the gap after STOP, written over the
// configuration channel, which is always ready.
// ----------------------------------------------------------------------------
module i2cm_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	i2cm_chan_if.sink         cfg,
	output i2cm_pkg::cfg_t    cfg_vals
);
	import i2cm_pkg::*;

	logic [HalfDelayW-1:0] half_delay_q;
	logic [StopGapW-1:0]   stop_gap_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_delay_q <= HALF_DELAY_RST;
			stop_gap_q   <= STOP_GAP_RST;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				CFG_HALF_DELAY: half_delay_q <= cfg.data.wdata[HalfDelayW-1:0];
				CFG_STOP_GAP:   stop_gap_q   <= cfg.data.wdata;
				default: ;
			endcase
		end
	end

	assign cfg_vals.half_delay = half_delay_q;
	assign cfg_vals.stop_gap   = stop_gap_q;

endmodule

FILE: src/i2cm_seq.sv
// ----------------------------------------------------------------------------
// I2C master byte transfer: bus sequencer
// Holds the transfer state and advances it by one tick for every accepted
// item. The result shows the state as it stood before the tick.
// ----------------------------------------------------------------------------
module i2cm_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick,
	input  i2cm_pkg::tick_t   tin,
	input  i2cm_pkg::cfg_t    cfg_vals,
	output i2cm_pkg::result_t res
);
	import i2cm_pkg::*;

	phase_t        phase_q, n_phase, tgt;
	logic [3:0]    bit_q, n_bit;
	logic [7:0]    shift_q, n_shift;
	logic [15:0]   wait_q, n_wait, wait_dec, hold_len;
	logic          mode_q, n_mode;
	logic [7:0]    hold_q, n_hold;
	logic          sda_q, n_sda;
	logic          scl_q, n_scl;
	logic          rel_q, n_rel;
	logic          bsel_q, n_bsel;
	logic          ack_q, n_ack;
	logic          go;
	logic          is_done, is_busy;

	assign is_done = (phase_q == PH_DONE);
	assign is_busy = (phase_q != PH_IDLE) && !is_done;

	always_comb begin
		res.scl_out     = scl_q;
		res.sda_out     = sda_q;
		res.sda_release = rel_q;
		res.busy_res    = is_busy;
		res.done_res    = is_done;
		res.success     = is_done && ack_q;
		res.read_byte   = (is_done && ack_q && !mode_q) ? shift_q : 8'd0;
	end

	// A hold time of zero behaves as one tick.
	assign hold_len = (cfg_vals.half_delay == '0) ? 16'd1
		: {{(StopGapW-HalfDelayW){1'b0}}, cfg_vals.half_delay};
	assign wait_dec = (wait_q != 16'd0) ? wait_q - 16'd1 : wait_q;

	always_comb begin
		n_phase = phase_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_wait  = wait_q;
		n_mode  = mode_q;
		n_hold  = hold_q;
		n_sda   = sda_q;
		n_scl   = scl_q;
		n_rel   = rel_q;
		n_bsel  = bsel_q;
		n_ack   = ack_q;
		go      = 1'b0;
		tgt     = phase_q;
		if (tick) begin
			if (phase_q == PH_IDLE) begin
				if (tin.start_req) begin
					n_mode  = tin.mode;
					n_shift = tin.addr_byte;
					n_hold  = tin.write_byte;
					n_bsel  = 1'b0;
					n_ack   = 1'b0;
					n_bit   = 4'd0;
					go      = 1'b1;
					tgt     = PH_ST0;
				end
			end else if (is_done) begin
				n_phase = PH_IDLE;
				n_wait  = 16'd0;
			end else begin
				n_wait = wait_dec;
				if (wait_dec == 16'd0) begin
					go = 1'b1;
					unique case (phase_q)
						PH_ST0:  tgt = PH_ST1;
						PH_ST1:  tgt = PH_ST2;
						PH_ST2:  tgt = PH_ST3;
						PH_ST3: begin
							n_bit = 4'd0;
							tgt   = PH_WSET;
						end
						PH_WSET: tgt = PH_WHI;
						PH_WHI:  tgt = PH_WLO;
						PH_WLO: begin
							n_shift = {shift_q[6:0], 1'b0};
							n_bit   = bit_q + 4'd1;
							tgt     = (n_bit < BITS_PER_BYTE) ? PH_WSET : PH_AHI;
						end
						PH_AHI: begin
							n_ack = !tin.sda_in;
							tgt   = PH_ALO;
						end
						PH_ALO: begin
							n_rel = 1'b0;
							if (!ack_q) begin
								tgt = PH_P0;
							end else if (!mode_q) begin
								tgt = PH_RPRE;
							end else if (!bsel_q) begin
								n_bsel  = 1'b1;
								n_shift = hold_q;
								n_bit   = 4'd0;
								tgt     = PH_WSET;
							end else begin
								tgt = PH_N0;
							end
						end
						PH_RPRE: tgt = PH_RHI;
						PH_RHI: begin
							n_shift = {shift_q[6:0], tin.sda_in};
							tgt     = PH_RLO;
						end
						PH_RLO: begin
							n_bit = bit_q + 4'd1;
							if (n_bit < BITS_PER_BYTE) begin
								tgt = PH_RHI;
							end else begin
								n_rel = 1'b0;
								tgt   = PH_N0;
							end
						end
						PH_N0:   tgt = PH_N1;
						PH_N1:   tgt = PH_N2;
						PH_N2:   tgt = PH_N3;
						PH_N3:   tgt = PH_P0;
						PH_P0:   tgt = PH_P1;
						PH_P1:   tgt = PH_P2;
						PH_P2:   tgt = (cfg_vals.stop_gap != '0) ? PH_GAP : PH_DONE;
						default: tgt = PH_DONE;
					endcase
				end
			end

			// Entering a phase reloads the hold counter and sets its pin level.
			if (go) begin
				n_phase = tgt;
				n_wait  = hold_len;
				unique case (tgt)
					PH_ST0:  n_sda = 1'b1;
					PH_ST1:  n_scl = 1'b1;
					PH_ST2:  n_sda = 1'b0;
					PH_ST3:  n_scl = 1'b0;
					PH_WSET: n_sda = n_shift[7];
					PH_WHI:  n_scl = 1'b1;
					PH_WLO:  n_scl = 1'b0;
					PH_AHI: begin
						n_rel = 1'b1;
						n_scl = 1'b1;
					end
					PH_ALO:  n_scl = 1'b0;
					PH_RPRE: begin
						n_rel   = 1'b1;
						n_bit   = 4'd0;
						n_shift = 8'd0;
					end
					PH_RHI:  n_scl = 1'b1;
					PH_RLO:  n_scl = 1'b0;
					PH_N0:   n_sda = 1'b1;
					PH_N1:   n_scl = 1'b1;
					PH_N2:   n_scl = 1'b0;
					PH_N3:   n_sda = 1'b0;
					PH_P0:   n_scl = 1'b0;
					PH_P1:   n_scl = 1'b1;
					PH_P2:   n_sda = 1'b1;
					PH_GAP:  n_wait = cfg_vals.stop_gap;
					default: n_wait = 16'd0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			wait_q  <= 16'd0;
			mode_q  <= 1'b0;
			hold_q  <= 8'd0;
			sda_q   <= 1'b1;
			scl_q   <= 1'b1;
			rel_q   <= 1'b0;
			bsel_q  <= 1'b0;
			ack_q   <= 1'b0;
		end else begin
			phase_q <= n_phase;
			bit_q   <= n_bit;
			shift_q <= n_shift;
			wait_q  <= n_wait;
			mode_q  <= n_mode;
			hold_q  <= n_hold;
			sda_q   <= n_sda;
			scl_q   <= n_scl;
			rel_q   <= n_rel;
			bsel_q  <= n_bsel;
			ack_q   <= n_ack;
		end
	end

	// SDA is only released around an ACK slot or while the read byte comes in.
	a_release_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rel_q |-> (phase_q == PH_AHI || phase_q == PH_ALO || phase_q == PH_RPRE ||
			phase_q == PH_RHI || phase_q == PH_RLO))
		else $error("SDA released outside an ACK or read phase");

	a_idle_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (wait_q == 16'd0))
		else $error("hold counter running while idle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && is_done) |=> (phase_q == PH_IDLE))
		else $error("done lasted more than one tick");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= BITS_PER_BYTE)
		else $error("bit counter beyond one byte");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tick |=> $stable(phase_q) && $stable(wait_q))
		else $error("sequencer moved without a tick");

endmodule

FILE: src/i2c_master_byte_transfer.sv
// ----------------------------------------------------------------------------
// I2C master byte transfer: top level
// Tick-driven bit-banged I2C master that reads or writes one byte.
// ----------------------------------------------------------------------------
// Usage:
// Every item on tick_in is one tick of the bus sequencer. It carries a start
// request with the mode, the address byte, the write byte and the sampled SDA
// level. Every accepted item gives exactly one item on res_out with the SCL
// and SDA levels, the SDA release flag, busy, the done pulse, the success
// flag and the read byte, as the sequencer stood before that tick.
// The cfg channel writes half_delay (index 0) and stop_gap (index 1); it is
// always ready. The user must write it only while no transfer is running;
// the block does not enforce this. Each result is registered, and one item
// is accepted every cycle while res_out is taken; the single pass through the
// sequencer logic between the state and result registers sets that rate.
// When the receiver stalls, the waiting result is held and tick_in is ready
// again in the cycle in which that result is taken.
// Reset puts the sequencer in idle with both lines high, the registers at
// half_delay 5 and stop_gap 1000, and empties the result register.
// ----------------------------------------------------------------------------
module i2c_master_byte_transfer (
	input  logic        clk,
	input  logic        arst_n,
	i2cm_chan_if.sink   tick_in,
	i2cm_chan_if.source res_out,
	i2cm_chan_if.sink   cfg
);
	import i2cm_pkg::*;

	cfg_t    cfg_vals;
	result_t seq_res;
	result_t res_q;
	logic    res_valid_q;
	logic    tick;

	assign tick_in.ready = !res_valid_q || res_out.ready;
	assign tick          = tick_in.valid && tick_in.ready;

	i2cm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_vals (cfg_vals)
	);

	i2cm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.tin      (tick_in.data),
		.cfg_vals (cfg_vals),
		.res      (seq_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tick) begin
			res_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			res_q <= seq_res;
		end
	end

	assign res_out.valid = res_valid_q;
	assign res_out.data  = res_q;

endmodule

FILE: tb/sv/i2c_master_byte_transfer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master byte transfer: self-checking testbench
// Feeds bus ticks that carry whole read and write transfers, with slave ACKs
// and read data placed on the sampling ticks. A predictor of the sequencer
// gives the expected result of every tick, and each result is compared field
// by field. Both channels idle at random, and the timing registers are set
// between transfers, zero values among them.
// ----------------------------------------------------------------------------
module i2c_master_byte_transfer_tb;
	import i2cm_pkg::*;

	localparam int StallLimit   = 2000;
	localparam int RandomTicks  = 220;
	localparam int SettleCycles = 8;
	localparam int MaxReports   = 40;

	typedef struct packed {
		phase_t                phase;
		logic [3:0]            bit_count;
		logic [7:0]            shift_reg;
		logic [15:0]           wait_count;
		logic                  op_mode;
		logic [7:0]            data_hold;
		logic                  sda_level;
		logic                  scl_level;
		logic                  sda_free;
		logic                  byte_sel;
		logic                  ack_ok;
		logic [HalfDelayW-1:0] half_delay;
		logic [StopGapW-1:0]   stop_gap;
	} seq_state_t;

	logic clk;
	logic arst_n;
	logic calm;
	logic random_part;

	tick_t      tick_q[$];
	result_t    expected_q[$];
	seq_state_t plan_st;
	seq_state_t bus_st;
	int         ticks_sent;
	int         ticks_taken;
	int         random_ticks;
	int         errors;
	int         idle_run;

	i2cm_chan_if #(.T(tick_t))   tick_if ();
	i2cm_chan_if #(.T(result_t)) res_if ();
	i2cm_chan_if #(.T(cfg_wr_t)) cfg_if ();

	i2c_master_byte_transfer u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick_in (tick_if),
		.res_out (res_if),
		.cfg     (cfg_if)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic seq_state_t reset_state();
		seq_state_t s;
		s = '0;
		s.phase = PH_IDLE;
		s.sda_level = 1'b1;
		s.scl_level = 1'b1;
		s.half_delay = HALF_DELAY_RST;
		s.stop_gap = STOP_GAP_RST;
		return s;
	endfunction

	function automatic tick_t random_tick();
		logic [31:0] rnd;
		rnd = $urandom;
		return rnd[$bits(tick_t)-1:0];
	endfunction

	// Moves to a phase, reloads the hold counter and applies the pin step.
	function automatic seq_state_t enter_phase(seq_state_t s, phase_t ph);
		s.phase = ph;
		s.wait_count = (s.half_delay == '0) ? 16'd1 : {8'd0, s.half_delay};
		case (ph)
			PH_ST0: s.sda_level = 1'b1;
			PH_ST1: s.scl_level = 1'b1;
			PH_ST2: s.sda_level = 1'b0;
			PH_ST3: s.scl_level = 1'b0;
			PH_WSET: s.sda_level = s.shift_reg[7];
			PH_WHI: s.scl_level = 1'b1;
			PH_WLO: s.scl_level = 1'b0;
			PH_AHI: begin
				s.sda_free = 1'b1;
				s.scl_level = 1'b1;
			end
			PH_ALO: s.scl_level = 1'b0;
			PH_RPRE: begin
				s.sda_free = 1'b1;
				s.bit_count = '0;
				s.shift_reg = '0;
			end
			PH_RHI: s.scl_level = 1'b1;
			PH_RLO: s.scl_level = 1'b0;
			PH_N0: s.sda_level = 1'b1;
			PH_N1: s.scl_level = 1'b1;
			PH_N2: s.scl_level = 1'b0;
			PH_N3: s.sda_level = 1'b0;
			PH_P0: s.scl_level = 1'b0;
			PH_P1: s.scl_level = 1'b1;
			PH_P2: s.sda_level = 1'b1;
			PH_GAP: s.wait_count = s.stop_gap;
			default: s.wait_count = '0;
		endcase
		return s;
	endfunction

	function automatic seq_state_t finish_step(seq_state_t s, logic sda);
		case (s.phase)
			PH_ST0: s = enter_phase(s, PH_ST1);
			PH_ST1: s = enter_phase(s, PH_ST2);
			PH_ST2: s = enter_phase(s, PH_ST3);
			PH_ST3: begin
				s.bit_count = '0;
				s = enter_phase(s, PH_WSET);
			end
			PH_WSET: s = enter_phase(s, PH_WHI);
			PH_WHI: s = enter_phase(s, PH_WLO);
			PH_WLO: begin
				s.shift_reg = {s.shift_reg[6:0], 1'b0};
				s.bit_count = s.bit_count + 4'd1;
				s = enter_phase(s, (s.bit_count < BITS_PER_BYTE) ? PH_WSET : PH_AHI);
			end
			PH_AHI: begin
				s.ack_ok = !sda;
				s = enter_phase(s, PH_ALO);
			end
			PH_ALO: begin
				s.sda_free = 1'b0;
				if (!s.ack_ok) begin
					s = enter_phase(s, PH_P0);
				end else if (!s.op_mode) begin
					s = enter_phase(s, PH_RPRE);
				end else if (!s.byte_sel) begin
					s.byte_sel = 1'b1;
					s.shift_reg = s.data_hold;
					s.bit_count = '0;
					s = enter_phase(s, PH_WSET);
				end else begin
					s = enter_phase(s, PH_N0);
				end
			end
			PH_RPRE: s = enter_phase(s, PH_RHI);
			PH_RHI: begin
				s.shift_reg = {s.shift_reg[6:0], sda};
				s = enter_phase(s, PH_RLO);
			end
			PH_RLO: begin
				s.bit_count = s.bit_count + 4'd1;
				if (s.bit_count < BITS_PER_BYTE) begin
					s = enter_phase(s, PH_RHI);
				end else begin
					s.sda_free = 1'b0;
					s = enter_phase(s, PH_N0);
				end
			end
			PH_N0: s = enter_phase(s, PH_N1);
			PH_N1: s = enter_phase(s, PH_N2);
			PH_N2: s = enter_phase(s, PH_N3);
			PH_N3: s = enter_phase(s, PH_P0);
			PH_P0: s = enter_phase(s, PH_P1);
			PH_P1: s = enter_phase(s, PH_P2);
			PH_P2: s = enter_phase(s, (s.stop_gap != '0) ? PH_GAP : PH_DONE);
			default: s = enter_phase(s, PH_DONE);
		endcase
		return s;
	endfunction

	function automatic seq_state_t next_state(seq_state_t s, tick_t t);
		if (s.phase == PH_IDLE) begin
			if (t.start_req) begin
				s.op_mode = t.mode;
				s.shift_reg = t.addr_byte;
				s.data_hold = t.write_byte;
				s.byte_sel = 1'b0;
				s.ack_ok = 1'b0;
				s.bit_count = '0;
				s = enter_phase(s, PH_ST0);
			end
		end else if (s.phase == PH_DONE) begin
			s.phase = PH_IDLE;
			s.wait_count = '0;
		end else begin
			if (s.wait_count != '0)
				s.wait_count = s.wait_count - 16'd1;
			if (s.wait_count == '0)
				s = finish_step(s, t.sda_in);
		end
		return s;
	endfunction

	// The pins and flags show the state as it stood before the tick.
	function automatic result_t bus_outputs(seq_state_t s);
		result_t r;
		r.scl_out = s.scl_level;
		r.sda_out = s.sda_level;
		r.sda_release = s.sda_free;
		r.done_res = (s.phase == PH_DONE);
		r.busy_res = (s.phase != PH_IDLE) && !r.done_res;
		r.success = r.done_res && s.ack_ok;
		r.read_byte = (r.success && !s.op_mode) ? s.shift_reg : 8'd0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		errors++;
		if (errors <= MaxReports)
			$display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got_v, want_v);
	endtask

	task automatic queue_tick(input tick_t t);
		plan_st = next_state(plan_st, t);
		tick_q.push_back(t);
		ticks_sent++;
		if (random_part)
			random_ticks++;
	endtask

	task automatic wait_drain();
		while (ticks_taken != ticks_sent || expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [StopGapW-1:0] wdata);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= {idx, wdata};
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		case (idx)
			CFG_HALF_DELAY: plan_st.half_delay = wdata[HalfDelayW-1:0];
			CFG_STOP_GAP: plan_st.stop_gap = wdata;
			default: ;
		endcase
	endtask

	// The upper bits of a half_delay write are filled with noise.
	task automatic set_timing(input logic [7:0] half_delay, input logic [15:0] stop_gap);
		logic [7:0] junk;
		junk = 8'($urandom);
		wait_drain();
		repeat (SettleCycles) @(posedge clk);
		write_reg(CFG_HALF_DELAY, {junk, half_delay});
		write_reg(CFG_STOP_GAP, stop_gap);
	endtask

	// Queues one transfer from its start tick to the tick after done. The slave
	// answers on the last high tick of each ACK and read bit; every other tick
	// carries noise, start requests included.
	task automatic run_transfer(input logic mode, input logic [7:0] addr, input logic [7:0] wbyte,
			input logic [7:0] rbyte, input logic ack_addr, input logic ack_data,
			input int pause_at);
		tick_t t;
		int n;
		t = random_tick();
		t.start_req = 1'b1;
		t.mode = mode;
		t.addr_byte = addr;
		t.write_byte = wbyte;
		queue_tick(t);
		n = 0;
		while (plan_st.phase != PH_IDLE) begin
			t = random_tick();
			if (plan_st.phase == PH_DONE)
				t.start_req = 1'($urandom_range(1));
			else
				t.start_req = ($urandom_range(9) == 0);
			if (plan_st.wait_count == 16'd1 && plan_st.phase == PH_AHI)
				t.sda_in = plan_st.byte_sel ? !ack_data : !ack_addr;
			else if (plan_st.wait_count == 16'd1 && plan_st.phase == PH_RHI)
				t.sda_in = rbyte[3'd7 - plan_st.bit_count[2:0]];
			queue_tick(t);
			n++;
			if (n == pause_at)
				wait_drain();
		end
		repeat ($urandom_range(3)) begin
			t = random_tick();
			t.start_req = 1'b0;
			queue_tick(t);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_if.valid <= 1'b0;
			tick_if.data <= '0;
		end else if (!tick_if.valid || tick_if.ready) begin
			if (tick_q.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
				tick_if.valid <= 1'b1;
				tick_if.data <= tick_q.pop_front();
			end else begin
				tick_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_if.ready <= 1'b0;
		else
			res_if.ready <= calm || ($urandom_range(99) >= 13);
	end

	// Results are checked before the new tick is predicted, so that a result
	// never meets the expectation of the tick accepted at the same edge.
	always @(posedge clk) begin : monitor
		result_t got;
		result_t want;
		if (!arst_n) begin
			bus_st = reset_state();
		end else begin
			if (res_if.valid && res_if.ready) begin
				got = res_if.data;
				if (expected_q.size() == 0) begin
					report_mismatch("result with nothing expected", int'(got), 0);
				end else begin
					want = expected_q.pop_front();
					if (got.scl_out !== want.scl_out)
						report_mismatch("scl_out", int'(got.scl_out), int'(want.scl_out));
					if (got.sda_out !== want.sda_out)
						report_mismatch("sda_out", int'(got.sda_out), int'(want.sda_out));
					if (got.sda_release !== want.sda_release)
						report_mismatch("sda_release", int'(got.sda_release),
							int'(want.sda_release));
					if (got.busy_res !== want.busy_res)
						report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
					if (got.done_res !== want.done_res)
						report_mismatch("done_res", int'(got.done_res), int'(want.done_res));
					if (got.success !== want.success)
						report_mismatch("success", int'(got.success), int'(want.success));
					if (got.read_byte !== want.read_byte)
						report_mismatch("read_byte", int'(got.read_byte),
							int'(want.read_byte));
				end
			end
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.data.index)
					CFG_HALF_DELAY: bus_st.half_delay = cfg_if.data.wdata[HalfDelayW-1:0];
					CFG_STOP_GAP: bus_st.stop_gap = cfg_if.data.wdata;
					default: ;
				endcase
			end
			if (tick_if.valid && tick_if.ready) begin
				expected_q.push_back(bus_outputs(bus_st));
				bus_st = next_state(bus_st, tick_if.data);
				ticks_taken++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready)
					|| (cfg_if.valid && cfg_if.ready)) begin
				idle_run <= 0;
			end else if (idle_run >= StallLimit) begin
				$display("i2c_master_byte_transfer regression: fail");
				$finish;
			end else begin
				idle_run <= idle_run + 1;
			end
		end
	end

	initial begin
		int round;
		arst_n = 1'b0;
		calm = 1'b0;
		random_part = 1'b0;
		ticks_sent = 0;
		random_ticks = 0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		plan_st = reset_state();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset half_delay first with a short gap, then reads and the failure paths
		// at the fastest timing.
		write_reg(CFG_STOP_GAP, 16'd2);
		run_transfer(1'b1, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, -1);
		set_timing(8'd1, 16'd0);
		run_transfer(1'b0, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1, 20);
		run_transfer(1'b0, 8'h81, 8'h3C, 8'h00, 1'b1, 1'b1, -1);
		run_transfer(1'b0, 8'h55, 8'h00, 8'hA5, 1'b0, 1'b1, -1);
		run_transfer(1'b1, 8'hAA, 8'h00, 8'h00, 1'b0, 1'b1, -1);
		run_transfer(1'b1, 8'hFF, 8'h5A, 8'h00, 1'b1, 1'b0, -1);
		// A zero half_delay behaves as one tick.
		set_timing(8'd0, 16'd1);
		run_transfer(1'b0, 8'h01, 8'h00, 8'h69, 1'b1, 1'b1, -1);
		run_transfer(1'b1, 8'hFE, 8'hC3, 8'h00, 1'b1, 1'b1, -1);
		set_timing(8'd2, 16'd20);
		run_transfer(1'b0, 8'hC3, 8'h00, 8'h96, 1'b1, 1'b1, -1);

		random_part = 1'b1;
		round = 0;
		while (random_ticks < RandomTicks) begin
			set_timing(8'(($urandom_range(99) < 20) ? $urandom_range(4, 5)
				: $urandom_range(1, 3)), 16'($urandom_range(0, 6)));
			calm = (round == 0);
			repeat ($urandom_range(1, 2))
				run_transfer(1'($urandom_range(1)), 8'($urandom), 8'($urandom),
					8'($urandom), $urandom_range(99) < 85, $urandom_range(99) < 85, -1);
			round++;
		end
		wait_drain();
		calm = 1'b0;
		random_part = 1'b0;

		repeat (SettleCycles) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("i2c_master_byte_transfer regression: pass");
		else
			$display("i2c_master_byte_transfer regression: fail");
		$finish;
	end

endmodule

FILE: i2c_master_byte_transfer.f
src/i2cm_pkg.sv
src/i2cm_chan_if.sv
src/i2cm_cfg_regs.sv
src/i2cm_seq.sv
src/i2c_master_byte_transfer.sv
tb/sv/i2c_master_byte_transfer_tb.sv
